@@ rtl/rflc_pkg.sv @@
// Shared types and constants for the receive frame layout checker.
package rflc_pkg;

  localparam int MAX_FRAMES        = 64;
  localparam int HEADER_BYTES      = 32;
  localparam int CAPTURE_DIR_BYTES = 36;
  localparam int MONITOR_DIR_BYTES = 24;
  localparam int META_BYTES        = 64;

  localparam int FLAG_W  = 16;
  localparam int LEN_W   = 32;
  localparam int HLEN_W  = 16;
  localparam int IDX_W   = 6;
  localparam int OFF_W   = 32;
  localparam int BATCH_W = 7;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = BATCH_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IDX_KIND  = 1'b0,
    CFG_IDX_BATCH = 1'b1
  } cfg_idx_t;

  // control area for the reset configuration: capture kind, one frame
  localparam logic [OFF_W-1:0] CTRL_RESET =
    OFF_W'(HEADER_BYTES + CAPTURE_DIR_BYTES + META_BYTES);

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INVALID    = 2'd1,
    ST_OVERFLOW   = 2'd2,
    ST_PRIOR_FAIL = 2'd3
  } status_t;

  typedef struct packed {
    logic [FLAG_W-1:0] flag_bits;
    logic [LEN_W-1:0]  chan_len;
    logic [LEN_W-1:0]  pkt_len;
    logic [LEN_W-1:0]  readable_len;
    logic [HLEN_W-1:0] header_len;
  } desc_t;

  typedef struct packed {
    logic [IDX_W-1:0] frame_index;
    status_t          status;
    logic [OFF_W-1:0] chan_offset;
    logic [OFF_W-1:0] pkt_offset;
    logic [OFF_W-1:0] tail_offset;
    logic [OFF_W-1:0] meta_offset;
    logic             batch_ok;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [OFF_W-1:0] cursor;
    logic [IDX_W-1:0] frame_cnt;
    logic             failed;
  } batch_state_t;

  typedef struct packed {
    logic               kind;
    logic [BATCH_W-1:0] batch_frames;
  } cfg_t;

endpackage

@@ rtl/rflc_in_if.sv @@
// Descriptor channel: valid/ready handshake with the frame descriptor fields.
interface rflc_in_if;
  import rflc_pkg::*;

  logic              valid;
  logic              ready;
  logic [FLAG_W-1:0] flag_bits;
  logic [LEN_W-1:0]  chan_len;
  logic [LEN_W-1:0]  pkt_len;
  logic [LEN_W-1:0]  readable_len;
  logic [HLEN_W-1:0] header_len;

  modport source (
    output valid, flag_bits, chan_len, pkt_len, readable_len, header_len,
    input  ready
  );
  modport sink (
    input  valid, flag_bits, chan_len, pkt_len, readable_len, header_len,
    output ready
  );
endinterface

@@ rtl/rflc_out_if.sv @@
// Result channel: valid/ready handshake with the layout result fields.
interface rflc_out_if;
  import rflc_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] frame_index;
  logic [1:0]       status;
  logic [OFF_W-1:0] chan_offset;
  logic [OFF_W-1:0] pkt_offset;
  logic [OFF_W-1:0] tail_offset;
  logic [OFF_W-1:0] meta_offset;
  logic             batch_ok;
  logic             last;

  modport source (
    output valid, frame_index, status, chan_offset, pkt_offset, tail_offset,
           meta_offset, batch_ok, last,
    input  ready
  );
  modport sink (
    input  valid, frame_index, status, chan_offset, pkt_offset, tail_offset,
           meta_offset, batch_ok, last,
    output ready
  );
endinterface

@@ rtl/rflc_frame_eval.sv @@
// Per-frame descriptor check and section placement against the batch cursor.
module rflc_frame_eval (
  input  rflc_pkg::cfg_t         cfg,
  input  rflc_pkg::desc_t        desc,
  input  rflc_pkg::batch_state_t st,
  output rflc_pkg::result_t      res,
  output rflc_pkg::batch_state_t st_nxt
);
  import rflc_pkg::*;

  function automatic logic desc_ok(
    input logic              kind,
    input logic [FLAG_W-1:0] flags,
    input logic [LEN_W-1:0]  clen,
    input logic [LEN_W-1:0]  plen,
    input logic [LEN_W-1:0]  rlen,
    input logic [HLEN_W-1:0] hlen
  );
    logic present, hdr_only, trunc, ptr_ok, parsed, ok;
    logic [LEN_W-1:0] hlen_x;
    present  = flags[0];
    hdr_only = flags[1];
    trunc    = flags[2];
    ptr_ok   = flags[3];
    parsed   = flags[4];
    hlen_x   = LEN_W'(hlen);
    ok       = 1'b1;
    if ((|flags[FLAG_W-1:5]) || (hlen_x > plen) || (plen > rlen)) begin
      ok = 1'b0;
    end else if (kind && (clen != '0)) begin
      ok = 1'b0;
    end else if (present != (plen != '0)) begin
      ok = 1'b0;
    end else if (parsed && !ptr_ok) begin
      ok = 1'b0;
    end else if (!present) begin
      ok = !hdr_only && !trunc && (hlen == '0);
    end else if (!ptr_ok) begin
      ok = 1'b0;
    end else if (hdr_only) begin
      ok = !trunc && (hlen_x == plen) && parsed;
    end else if ((plen < rlen) && !trunc) begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  logic [BATCH_W-1:0] n_eff;
  logic [BATCH_W-1:0] idx_x;
  logic [IDX_W-1:0]   idx;
  logic               batch_start;
  logic               is_last;
  logic [OFF_W-1:0]   dir_sz;
  logic [OFF_W-1:0]   meta_base;
  logic [OFF_W-1:0]   ctrl_size;
  logic [OFF_W-1:0]   cur;
  logic               failed_in;
  logic               valid_desc;
  logic [OFF_W:0]     sum1;
  logic [OFF_W+1:0]   algn1;
  logic [OFF_W-1:0]   p_at;
  logic [OFF_W:0]     sum2;
  logic [OFF_W+1:0]   algn2;
  logic               ovf;
  status_t            status;
  logic               placed;
  logic               failed_out;

  always_comb begin
    if (cfg.batch_frames == '0) begin
      n_eff = BATCH_W'(1);
    end else if (cfg.batch_frames > BATCH_W'(MAX_FRAMES)) begin
      n_eff = BATCH_W'(MAX_FRAMES);
    end else begin
      n_eff = cfg.batch_frames;
    end
  end

  // counter left beyond a shrunken batch size wraps to the start
  assign idx_x       = (BATCH_W'(st.frame_cnt) >= n_eff) ? '0 : BATCH_W'(st.frame_cnt);
  assign idx         = idx_x[IDX_W-1:0];
  assign batch_start = (idx_x == '0);
  assign is_last     = ((idx_x + BATCH_W'(1)) == n_eff);

  assign dir_sz    = cfg.kind ? OFF_W'(MONITOR_DIR_BYTES) : OFF_W'(CAPTURE_DIR_BYTES);
  assign meta_base = OFF_W'(HEADER_BYTES) + OFF_W'(n_eff) * dir_sz;
  assign ctrl_size = meta_base + OFF_W'(n_eff) * OFF_W'(META_BYTES);

  assign cur       = batch_start ? ctrl_size : st.cursor;
  assign failed_in = batch_start ? 1'b0 : st.failed;

  assign valid_desc = desc_ok(cfg.kind, desc.flag_bits, desc.chan_len, desc.pkt_len,
                              desc.readable_len, desc.header_len);

  // add then round up to a 4-byte boundary; carry bits flag overflow
  assign sum1  = {1'b0, cur} + {1'b0, desc.chan_len};
  assign algn1 = ({1'b0, sum1} + (OFF_W+2)'(3)) & ~(OFF_W+2)'(3);
  assign p_at  = algn1[OFF_W-1:0];
  assign sum2  = {1'b0, p_at} + {1'b0, desc.pkt_len};
  assign algn2 = ({1'b0, sum2} + (OFF_W+2)'(3)) & ~(OFF_W+2)'(3);
  assign ovf   = (|algn1[OFF_W+1:OFF_W]) || (|algn2[OFF_W+1:OFF_W]);

  always_comb begin
    if (failed_in) begin
      status = ST_PRIOR_FAIL;
    end else if (!valid_desc) begin
      status = ST_INVALID;
    end else if (ovf) begin
      status = ST_OVERFLOW;
    end else begin
      status = ST_OK;
    end
  end

  assign placed     = (status == ST_OK);
  assign failed_out = failed_in || !placed;

  assign res.frame_index = idx;
  assign res.status      = status;
  assign res.chan_offset = (placed && (desc.chan_len != '0)) ? cur : '0;
  assign res.pkt_offset  = (placed && (desc.pkt_len != '0)) ? p_at : '0;
  assign res.tail_offset = placed ? algn2[OFF_W-1:0] : '0;
  assign res.meta_offset = meta_base + OFF_W'(idx) * OFF_W'(META_BYTES);
  assign res.batch_ok    = !failed_out;
  assign res.last        = is_last;

  assign st_nxt.cursor    = placed ? algn2[OFF_W-1:0] : cur;
  assign st_nxt.frame_cnt = is_last ? '0 : IDX_W'(idx_x + BATCH_W'(1));
  assign st_nxt.failed    = failed_out;

endmodule

@@ rtl/rx_frame_layout_checker.sv @@
// Top level: descriptor register, layout evaluation, result register, batch state.
// Path: a word accepted on the descriptor channel is held in the descriptor register,
// then in the result register, from which it is presented on the result channel.
// Throughput: one word per cycle while out_ch.ready holds; the cursor update for a
// frame ends in the same cycle that evaluates it; the next frame sees it, no bubble.
// Reset (synchronous, rst_n low): both channels empty, counter and fail flag clear,
// capture kind 0, batch size 1, cursor at the control area size for that setup.
module rx_frame_layout_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  rflc_in_if.sink                          in_ch,
  rflc_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [rflc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rflc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rflc_pkg::*;

  cfg_t         cfg_r;
  desc_t        desc_r;
  logic         in_vld_r;
  result_t      res_r;
  result_t      res_nxt;
  logic         out_vld_r;
  batch_state_t st_r;
  batch_state_t st_nxt;
  logic         advance;

  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kind         <= 1'b0;
      cfg_r.batch_frames <= BATCH_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IDX_KIND:  cfg_r.kind         <= cfg_wdata[0];
        CFG_IDX_BATCH: cfg_r.batch_frames <= cfg_wdata[BATCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      desc_r.flag_bits    <= in_ch.flag_bits;
      desc_r.chan_len     <= in_ch.chan_len;
      desc_r.pkt_len      <= in_ch.pkt_len;
      desc_r.readable_len <= in_ch.readable_len;
      desc_r.header_len   <= in_ch.header_len;
    end
  end

  rflc_frame_eval u_eval (
    .cfg    (cfg_r),
    .desc   (desc_r),
    .st     (st_r),
    .res    (res_nxt),
    .st_nxt (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.cursor    <= CTRL_RESET;
      st_r.frame_cnt <= '0;
      st_r.failed    <= 1'b0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.frame_index = res_r.frame_index;
  assign out_ch.status      = res_r.status;
  assign out_ch.chan_offset = res_r.chan_offset;
  assign out_ch.pkt_offset  = res_r.pkt_offset;
  assign out_ch.tail_offset = res_r.tail_offset;
  assign out_ch.meta_offset = res_r.meta_offset;
  assign out_ch.batch_ok    = res_r.batch_ok;
  assign out_ch.last        = res_r.last;

  // a placed frame never reports a failed batch
  a_ok_means_batch_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (res_r.status == ST_OK)) |-> res_r.batch_ok)
    else $error("ok frame reported with batch_ok low");

  // rejected frames carry no channel, packet or tail offsets and clear batch_ok
  a_fail_zero_offsets: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (res_r.status != ST_OK)) |->
      (!res_r.batch_ok && (res_r.tail_offset == '0) && (res_r.pkt_offset == '0)
       && (res_r.chan_offset == '0)))
    else $error("failed frame carries offsets");

  // the final frame of a batch brings the counter back to zero
  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_nxt.last) |=> (st_r.frame_cnt == '0))
    else $error("frame counter did not wrap after last frame");

  // packet section of a placed frame sits at or after its channel section
  a_section_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (res_r.status == ST_OK) && (res_r.pkt_offset != '0)) |->
      ((res_r.pkt_offset >= res_r.chan_offset)
       && (res_r.tail_offset >= res_r.pkt_offset)))
    else $error("section offsets out of order");

endmodule
